>>> design/page_allocator_refcount_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the page allocator.
// They expect clk and rst in scope at the place of use.
// ---------------------------------------------------------------------------
`ifndef PAGE_ALLOCATOR_REFCOUNT_ASSERT_SVH
`define PAGE_ALLOCATOR_REFCOUNT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/pa_pkg.sv
// ---------------------------------------------------------------------------
// pa_pkg
// Shared constants, codes and types of the page allocator.
// ---------------------------------------------------------------------------
package pa_pkg;

  localparam int unsigned PAGE_COUNT_DEF = 32768;
  localparam int unsigned PAGE_BYTES_DEF = 4096;
  localparam int unsigned REF_BITS_DEF   = 16;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned TYPE_W     = 2;
  localparam int unsigned REFV_W     = 16;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [ADDR_W-1:0] MEM_BASE_RST     = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] USABLE_START_RST = 32'h8000_0000;

  // Request types
  localparam logic [TYPE_W-1:0] REQ_ALLOC  = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_FREE   = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_ADDREF = 2'd2;
  localparam logic [TYPE_W-1:0] REQ_GETREF = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OOM       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADADDR   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_BASE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USABLE_START = 1'd1;

  typedef struct packed {
    logic in_range;
    logic aligned;
    logic below_usable;
  } addr_info_t;

endpackage

>>> design/pa_req_if.sv
// ---------------------------------------------------------------------------
// pa_req_if
// Request channel of the page allocator: valid/ready with type and address.
// ---------------------------------------------------------------------------
interface pa_req_if;
  logic                          valid;
  logic                          ready;
  logic [pa_pkg::TYPE_W-1:0]     req_type;
  logic [pa_pkg::ADDR_W-1:0]     page_addr;

  modport source (output valid, req_type, page_addr, input ready);
  modport sink   (input valid, req_type, page_addr, output ready);
endinterface

>>> design/pa_rsp_if.sv
// ---------------------------------------------------------------------------
// pa_rsp_if
// Response channel of the page allocator: valid/ready with the result fields.
// ---------------------------------------------------------------------------
interface pa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pa_pkg::ADDR_W-1:0]     alloc_addr;
  logic [pa_pkg::REFV_W-1:0]     ref_value;
  logic                          page_released;
  logic [pa_pkg::STATUS_W-1:0]   status;

  modport source (output valid, alloc_addr, ref_value, page_released, status, input ready);
  modport sink   (input valid, alloc_addr, ref_value, page_released, status, output ready);
endinterface

>>> design/pa_ram.sv
// ---------------------------------------------------------------------------
// pa_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module pa_ram #(
  parameter int unsigned DEPTH = pa_pkg::PAGE_COUNT_DEF,
  parameter int unsigned WIDTH = pa_pkg::REF_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read enable.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/pa_addr.sv
// ---------------------------------------------------------------------------
// pa_addr
// Address decode: page index, range, alignment and usable-start checks.
// ---------------------------------------------------------------------------
module pa_addr #(
  parameter int unsigned PAGE_COUNT = pa_pkg::PAGE_COUNT_DEF,
  parameter int unsigned PAGE_BYTES = pa_pkg::PAGE_BYTES_DEF
) (
  input  logic [pa_pkg::ADDR_W-1:0]     addr,
  input  logic [pa_pkg::ADDR_W-1:0]     mem_base,
  input  logic [pa_pkg::ADDR_W-1:0]     usable_start,
  output logic [$clog2(PAGE_COUNT)-1:0] idx,
  output pa_pkg::addr_info_t            info
);

  localparam int unsigned IDX_W      = $clog2(PAGE_COUNT);
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned SPAN_W     = pa_pkg::ADDR_W + 5;
  localparam logic [SPAN_W-1:0] SPAN = SPAN_W'(PAGE_COUNT) << PAGE_SHIFT;

  logic [pa_pkg::ADDR_W:0]   diff;
  logic [pa_pkg::ADDR_W-1:0] offset;

  // The top bit of the difference is the borrow: address below the base.
  assign diff   = {1'b0, addr} - {1'b0, mem_base};
  assign offset = diff[pa_pkg::ADDR_W-1:0];
  assign idx    = IDX_W'(offset >> PAGE_SHIFT);

  assign info.in_range     = !diff[pa_pkg::ADDR_W] && (SPAN_W'(offset) < SPAN);
  assign info.aligned      = (addr[PAGE_SHIFT-1:0] == '0);
  assign info.below_usable = (addr < usable_start);

endmodule

>>> design/page_allocator_refcount.sv
// ---------------------------------------------------------------------------
// page_allocator_refcount
// Physical page frame allocator with a LIFO free stack and per-page
// reference counts held in two synchronous RAMs.
// ---------------------------------------------------------------------------
// Usage: after reset the count RAM is swept to zero, one page per cycle, so
// the request channel stays not-ready until all PAGE_COUNT pages (32768 with
// the default size) are cleared; configuration writes are taken during that
// sweep. Each request is then handled in an accept cycle, which issues the
// reads of the free stack and the count table, and an execute cycle, which,
// once the response register is free, applies the update and loads the
// response. The reads of the two RAMs are registered, and no new request is
// taken until the current one has executed. PAGE_BYTES must be a power of two.
// The free stack starts empty; pages enter it only through free requests.
// ---------------------------------------------------------------------------
module page_allocator_refcount #(
  parameter int unsigned PAGE_COUNT = pa_pkg::PAGE_COUNT_DEF,
  parameter int unsigned PAGE_BYTES = pa_pkg::PAGE_BYTES_DEF,
  parameter int unsigned REF_BITS   = pa_pkg::REF_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pa_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [pa_pkg::CFG_DATA_W-1:0]   cfg_data,
  pa_req_if.sink                          req,
  pa_rsp_if.source                        rsp
);

  localparam int unsigned IDX_W      = $clog2(PAGE_COUNT);
  localparam int unsigned TOP_W      = $clog2(PAGE_COUNT + 1);
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned OFF_W      = IDX_W + PAGE_SHIFT;

  typedef enum logic [2:0] {
    S_INIT = 3'b001,
    S_IDLE = 3'b010,
    S_EX   = 3'b100
  } state_t;

  state_t state, state_next;

  logic [pa_pkg::ADDR_W-1:0] mem_base, usable_start;
  logic [IDX_W-1:0]          clr_idx;
  logic [TOP_W-1:0]          free_top, top_next;

  // Captured request
  logic [pa_pkg::TYPE_W-1:0] rq_type;
  logic [IDX_W-1:0]          rq_idx;
  logic                      rq_bad;

  // Decode of the incoming address
  logic [IDX_W-1:0]          dec_idx;
  pa_pkg::addr_info_t        dec_info;
  logic                      dec_bad;

  logic                      accept, advance, init_last;

  // RAM ports
  logic [IDX_W-1:0]          stk_rd;
  logic [REF_BITS-1:0]       ref_rd;
  logic                      ref_we, ref_we_m, stk_we, stk_we_m;
  logic [IDX_W-1:0]          ref_waddr, ref_waddr_m;
  logic [REF_BITS-1:0]       ref_wdata, ref_wdata_m;

  // Result
  logic [pa_pkg::ADDR_W-1:0]   o_alloc;
  logic [REF_BITS-1:0]         o_cnt;
  logic                        o_rel;
  logic [pa_pkg::STATUS_W-1:0] o_st;
  logic [OFF_W-1:0]            page_off;
  logic [REF_BITS+15:0]        cnt_ext;

  logic                        rsp_valid;
  logic [pa_pkg::ADDR_W-1:0]   rsp_alloc;
  logic [pa_pkg::REFV_W-1:0]   rsp_refv;
  logic                        rsp_rel;
  logic [pa_pkg::STATUS_W-1:0] rsp_st;

  pa_addr #(
    .PAGE_COUNT (PAGE_COUNT),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_addr (
    .addr         (req.page_addr),
    .mem_base     (mem_base),
    .usable_start (usable_start),
    .idx          (dec_idx),
    .info         (dec_info)
  );

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign advance   = (state == S_EX) && (!rsp_valid || rsp.ready);
  assign init_last = (clr_idx == IDX_W'(PAGE_COUNT - 1));

  // Free requires an aligned, usable address; the reference requests accept
  // any address inside managed memory.
  assign dec_bad = (req.req_type == pa_pkg::REQ_FREE)
                 ? (!dec_info.aligned || dec_info.below_usable || !dec_info.in_range)
                 : !dec_info.in_range;

  pa_ram #(
    .DEPTH (PAGE_COUNT),
    .WIDTH (IDX_W)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we_m),
    .waddr (IDX_W'(free_top)),
    .wdata (rq_idx),
    .re    (accept),
    .raddr (IDX_W'(free_top - 1'b1)),
    .rdata (stk_rd)
  );

  pa_ram #(
    .DEPTH (PAGE_COUNT),
    .WIDTH (REF_BITS)
  ) u_refs (
    .clk   (clk),
    .we    (ref_we_m),
    .waddr (ref_waddr_m),
    .wdata (ref_wdata_m),
    .re    (accept),
    .raddr (dec_idx),
    .rdata (ref_rd)
  );

  assign page_off = {stk_rd, {PAGE_SHIFT{1'b0}}};

  always_comb begin
    o_alloc   = '0;
    o_cnt     = '0;
    o_rel     = 1'b0;
    o_st      = pa_pkg::ST_OK;
    top_next  = free_top;
    ref_we    = 1'b0;
    ref_waddr = rq_idx;
    ref_wdata = '0;
    stk_we    = 1'b0;
    case (rq_type)
      pa_pkg::REQ_ALLOC: begin
        if (free_top == '0) begin
          o_st = pa_pkg::ST_OOM;
        end else begin
          top_next  = free_top - 1'b1;
          ref_we    = 1'b1;
          ref_waddr = stk_rd;
          ref_wdata = REF_BITS'(1);
          o_cnt     = REF_BITS'(1);
          o_alloc   = mem_base + pa_pkg::ADDR_W'(page_off);
        end
      end
      pa_pkg::REQ_FREE: begin
        if (rq_bad) begin
          o_st = pa_pkg::ST_BADADDR;
        end else if (ref_rd > REF_BITS'(1)) begin
          ref_we    = 1'b1;
          ref_wdata = ref_rd - 1'b1;
          o_cnt     = ref_rd - 1'b1;
        end else if (free_top == TOP_W'(PAGE_COUNT)) begin
          o_st  = pa_pkg::ST_OVERFLOW;
          o_cnt = ref_rd;
        end else begin
          ref_we   = 1'b1;
          stk_we   = 1'b1;
          top_next = free_top + 1'b1;
          o_rel    = 1'b1;
        end
      end
      pa_pkg::REQ_ADDREF: begin
        if (rq_bad) begin
          o_st = pa_pkg::ST_BADADDR;
        end else if (ref_rd == {REF_BITS{1'b1}}) begin
          o_st  = pa_pkg::ST_SATURATED;
          o_cnt = ref_rd;
        end else begin
          ref_we    = 1'b1;
          ref_wdata = ref_rd + 1'b1;
          o_cnt     = ref_rd + 1'b1;
        end
      end
      pa_pkg::REQ_GETREF: begin
        if (rq_bad) begin
          o_st = pa_pkg::ST_BADADDR;
        end else begin
          o_cnt = ref_rd;
        end
      end
      default: begin
        o_st = pa_pkg::ST_OK;
      end
    endcase
  end

  // The clearing sweep owns the count RAM write port until it finishes.
  assign ref_we_m    = (state == S_INIT) || (advance && ref_we);
  assign ref_waddr_m = (state == S_INIT) ? clr_idx : ref_waddr;
  assign ref_wdata_m = (state == S_INIT) ? '0 : ref_wdata;
  assign stk_we_m    = advance && stk_we;

  assign cnt_ext = {16'b0, o_cnt};

  always_comb begin
    state_next = state;
    case (state)
      S_INIT:  if (init_last) state_next = S_IDLE;
      S_IDLE:  if (accept)    state_next = S_EX;
      S_EX:    if (advance)   state_next = S_IDLE;
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      clr_idx      <= '0;
      free_top     <= '0;
      rsp_valid    <= 1'b0;
      mem_base     <= pa_pkg::MEM_BASE_RST;
      usable_start <= pa_pkg::USABLE_START_RST;
    end else begin
      state <= state_next;
      if (state == S_INIT) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (advance) begin
        free_top <= top_next;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_idx)
          pa_pkg::CFG_MEM_BASE:     mem_base     <= cfg_data;
          pa_pkg::CFG_USABLE_START: usable_start <= cfg_data;
          default:                  mem_base     <= mem_base;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rq_type <= req.req_type;
      rq_idx  <= dec_idx;
      rq_bad  <= dec_bad;
    end
    if (advance) begin
      rsp_alloc <= o_alloc;
      rsp_refv  <= cnt_ext[15:0];
      rsp_rel   <= o_rel;
      rsp_st    <= o_st;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.alloc_addr    = rsp_alloc;
  assign rsp.ref_value     = rsp_refv;
  assign rsp.page_released = rsp_rel;
  assign rsp.status        = rsp_st;

`include "page_allocator_refcount_assert.svh"

  `PA_ASSERT_IMP(a_no_req_in_init, state == S_INIT, !req.ready, "request taken during clear sweep")
  `PA_ASSERT_IMP(a_top_bound, 1'b1, free_top <= TOP_W'(PAGE_COUNT), "free stack pointer overran")
  `PA_ASSERT_NXT(a_accept_exec, accept, state == S_EX, "accepted request did not reach execute")
  `PA_ASSERT_NXT(a_alloc_pop, advance && rq_type == pa_pkg::REQ_ALLOC && free_top != '0, free_top == $past(free_top) - 1'b1, "alloc did not pop the free stack")
  `PA_ASSERT_NXT(a_rsp_loaded, advance, rsp.valid, "executed request gave no response")

endmodule
